>>> rtl/core/pfp_pkg.sv
// ----------------------------------------------------------------------------
// pfp_pkg: shared types and constants of the plane-from-three-points unit
// Widths of the normalized cross product, the square-root datapath and the
// projection plane codes.
// ----------------------------------------------------------------------------
package pfp_pkg;

   localparam int NORM_BITS   = 31;
   localparam int SUM_BITS    = 64;
   localparam int ROOT_BITS   = SUM_BITS / 2;
   localparam int REM_BITS    = ROOT_BITS + 3;
   localparam int OFFSET_BITS = 34;
   localparam int NORMAL_BITS = 32;

   typedef enum logic [1:0] {
      PROJ_YZ = 2'd0,
      PROJ_XZ = 2'd1,
      PROJ_XY = 2'd2
   } proj_type;

   typedef struct packed {
      logic [SUM_BITS-1:0]  radicand;
      logic [REM_BITS-1:0]  rem;
      logic [ROOT_BITS-1:0] root;
   } sqrt_type;

endpackage

>>> rtl/core/pfp_sqrt_cell.sv
// ----------------------------------------------------------------------------
// pfp_sqrt_cell: one digit of the integer square root
// Brings down two radicand bits, tries the next root bit and registers the
// partial root, remainder and the side data of the transaction.
// ----------------------------------------------------------------------------
module pfp_sqrt_cell #(
   parameter int SIDE_W = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  pfp_pkg::sqrt_type    in_data,
   input  logic [SIDE_W-1:0]    in_side,
   output logic                 out_valid,
   output pfp_pkg::sqrt_type    out_data,
   output logic [SIDE_W-1:0]    out_side
);
   import pfp_pkg::*;

   logic                 valid_ff;
   sqrt_type             data_ff;
   sqrt_type             data_in;
   logic [SIDE_W-1:0]    side_ff;
   logic [REM_BITS-1:0]  rem_sh;
   logic [REM_BITS-1:0]  trial;

   always_comb begin
      rem_sh = {in_data.rem[REM_BITS-3:0], in_data.radicand[SUM_BITS-1 -: 2]};
      trial  = {1'b0, in_data.root, 2'b01};
      data_in.radicand = {in_data.radicand[SUM_BITS-3:0], 2'b00};
      if (rem_sh >= trial) begin
         data_in.rem  = rem_sh - trial;
         data_in.root = {in_data.root[ROOT_BITS-2:0], 1'b1};
      end else begin
         data_in.rem  = rem_sh;
         data_in.root = {in_data.root[ROOT_BITS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      data_ff <= data_in;
      side_ff <= in_side;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign out_side  = side_ff;

endmodule

>>> rtl/core/pfp_div_cell.sv
// ----------------------------------------------------------------------------
// pfp_div_cell: one quotient bit of three parallel restoring divisions
// Each lane shifts its remainder and dividend word left, subtracts the
// shared divisor when it fits and shifts the quotient bit in at the bottom.
// ----------------------------------------------------------------------------
module pfp_div_cell #(
   parameter int QB     = 31,
   parameter int SIDE_W = 8
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   input  logic [pfp_pkg::ROOT_BITS-1:0]           in_divisor,
   input  logic [2:0][pfp_pkg::ROOT_BITS+QB-1:0]   in_work,
   input  logic [SIDE_W-1:0]                       in_side,
   output logic                                    out_valid,
   output logic [pfp_pkg::ROOT_BITS-1:0]           out_divisor,
   output logic [2:0][pfp_pkg::ROOT_BITS+QB-1:0]   out_work,
   output logic [SIDE_W-1:0]                       out_side
);
   import pfp_pkg::*;

   localparam int RB = ROOT_BITS;

   logic                      valid_ff;
   logic [RB-1:0]             divisor_ff;
   logic [2:0][RB+QB-1:0]     work_ff;
   logic [2:0][RB+QB-1:0]     work_in;
   logic [SIDE_W-1:0]         side_ff;
   logic [RB:0]               trial;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         trial = {in_work[j][RB+QB-1:QB], in_work[j][QB-1]};
         if (trial >= {1'b0, in_divisor}) begin
            work_in[j] = {RB'(trial - {1'b0, in_divisor}), in_work[j][QB-2:0], 1'b1};
         end else begin
            work_in[j] = {trial[RB-1:0], in_work[j][QB-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      divisor_ff <= in_divisor;
      work_ff    <= work_in;
      side_ff    <= in_side;
   end

   assign out_valid   = valid_ff;
   assign out_divisor = divisor_ff;
   assign out_work    = work_ff;
   assign out_side    = side_ff;

endmodule

>>> rtl/core/plane_from_three_points_unit.sv
// ----------------------------------------------------------------------------
// plane_from_three_points_unit: plane equation from three points
// Forms the unit normal, plane offset and dominant projection plane of the
// plane through three integer points.
// ----------------------------------------------------------------------------
// Usage: a transaction is taken at every rising edge with start high; busy
// is always low, so one triangle can be issued in every cycle. The nine
// coordinates ride on the req_ ports. Each result shows on the rsp_ ports
// for one cycle with rsp_valid high, and results leave in issue order.
// The pipeline has seven setup stages (edges, products, cross product,
// leading-one search, normalizing shift, squares, sum), a row of 32
// square-root cells, one divider setup stage, a row of NORMAL_FRAC_BITS + 1
// divider cells shared by the three components, and three stages for the
// offset dot product, rescaling and the output.
// Throughput is one transaction per cycle.
// The receiver cannot stall: a result is gone after its cycle.
// Synchronous reset empties the pipeline; transactions in flight are lost
// and no result appears until new transactions have passed through.
// ----------------------------------------------------------------------------
module plane_from_three_points_unit #(
   parameter int COORD_BITS       = 16,
   parameter int NORMAL_FRAC_BITS = 30,
   parameter int OFFSET_FRAC_BITS = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   output logic                                     busy,
   input  logic signed [COORD_BITS-1:0]             req_first_x,
   input  logic signed [COORD_BITS-1:0]             req_first_y,
   input  logic signed [COORD_BITS-1:0]             req_first_z,
   input  logic signed [COORD_BITS-1:0]             req_second_x,
   input  logic signed [COORD_BITS-1:0]             req_second_y,
   input  logic signed [COORD_BITS-1:0]             req_second_z,
   input  logic signed [COORD_BITS-1:0]             req_third_x,
   input  logic signed [COORD_BITS-1:0]             req_third_y,
   input  logic signed [COORD_BITS-1:0]             req_third_z,
   output logic                                     rsp_valid,
   output logic signed [pfp_pkg::NORMAL_BITS-1:0]   rsp_normal_x,
   output logic signed [pfp_pkg::NORMAL_BITS-1:0]   rsp_normal_y,
   output logic signed [pfp_pkg::NORMAL_BITS-1:0]   rsp_normal_z,
   output logic signed [pfp_pkg::OFFSET_BITS-1:0]   rsp_plane_offset,
   output logic [1:0]                               rsp_projection_plane,
   output logic                                     rsp_degenerate
);
   import pfp_pkg::*;

   localparam int CB    = COORD_BITS;
   localparam int F     = NORMAL_FRAC_BITS;
   localparam int EW    = CB + 1;
   localparam int SEW   = (EW > 32) ? 32 : EW;
   localparam int CW    = 2 * SEW + 1;
   localparam int CMW   = 2 * SEW;
   localparam int LW    = $clog2(CMW + 1);
   localparam int QB    = F + 1;
   localparam int RB    = ROOT_BITS;
   localparam int NW    = F + 2;
   localparam int PW    = NW + CB;
   localparam int DW    = PW + 2;
   localparam int RW0   = DW + 11;
   localparam int RW    = (RW0 > 42) ? RW0 : 42;
   localparam int NSQ   = ROOT_BITS;
   localparam int SQ_SIDE_W  = 1 + 3 + 3 * NORM_BITS + 3 * CB;
   localparam int DIV_SIDE_W = 1 + 3 + 3 * CB;

   // Stage 1: edges
   logic                          v1_ff;
   logic signed [2:0][CB-1:0]     p_ff [1:7];
   logic signed [SEW-1:0]         e_ff [2][3];
   logic signed [SEW-1:0]         e_in [2][3];
   logic signed [CB-1:0]          pt [3][3];
   logic signed [EW-1:0]          diff;
   logic [EW-1:0]                 em [2][3];
   logic                          eneg [2][3];
   logic                          big;
   logic [EW-1:0]                 ems;
   logic signed [EW-1:0]          ev;

   always_comb begin
      pt[0] = '{req_first_x, req_first_y, req_first_z};
      pt[1] = '{req_second_x, req_second_y, req_second_z};
      pt[2] = '{req_third_x, req_third_y, req_third_z};
      big = 1'b0;
      for (int k = 0; k < 2; k++) begin
         for (int j = 0; j < 3; j++) begin
            diff = EW'(pt[k+1][j]) - EW'(pt[0][j]);
            eneg[k][j] = diff[EW-1];
            em[k][j] = diff[EW-1] ? EW'(-diff) : EW'(diff);
            big = big | ((em[k][j] >> 31) != '0);
         end
      end
      for (int k = 0; k < 2; k++) begin
         for (int j = 0; j < 3; j++) begin
            ems = big ? (em[k][j] >> 1) : em[k][j];
            ev = eneg[k][j] ? -$signed(ems) : $signed(ems);
            e_in[k][j] = ev[SEW-1:0];
         end
      end
   end

   // Stage 2: products; stage 3: cross product
   logic                          v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff;
   logic signed [2*SEW-1:0]       pr_ff [6];
   logic [CMW-1:0]                cm_ff [3];
   logic [CMW-1:0]                cm_in [3];
   logic [2:0]                    cneg_ff [3:7];
   logic [2:0]                    cneg_in;
   logic                          deg_ff [3:7];
   logic signed [CW-1:0]          cv;
   logic [LW-1:0]                 lead_ff;
   logic [LW-1:0]                 lead_in;
   logic [CMW-1:0]                cor;
   logic [CMW-1:0]                cm4_ff [3];
   logic [NORM_BITS-1:0]          nm_ff [5:7][3];
   logic [NORM_BITS-1:0]          nm_in [3];
   logic [CMW+NORM_BITS-1:0]      ext;
   logic [2*NORM_BITS-1:0]        sq_ff [3];
   logic [SUM_BITS-1:0]           sum_ff;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         cv = CW'(pr_ff[2*j]) - CW'(pr_ff[2*j+1]);
         cneg_in[j] = cv[CW-1];
         cm_in[j] = cv[CW-1] ? CMW'(-cv) : CMW'(cv);
      end
      cor = cm_ff[0] | cm_ff[1] | cm_ff[2];
      lead_in = '0;
      for (int i = 0; i < CMW; i++) begin
         if (cor[i]) begin
            lead_in = LW'(i);
         end
      end
      for (int j = 0; j < 3; j++) begin
         ext = {cm4_ff[j], {NORM_BITS{1'b0}}} >> (lead_ff + 1'b1);
         nm_in[j] = ext[NORM_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
      p_ff[1] <= {req_first_x, req_first_y, req_first_z};
      for (int s = 2; s <= 7; s++) begin
         p_ff[s] <= p_ff[s-1];
      end
      e_ff <= e_in;
      pr_ff[0] <= e_ff[0][1] * e_ff[1][2];
      pr_ff[1] <= e_ff[0][2] * e_ff[1][1];
      pr_ff[2] <= e_ff[0][2] * e_ff[1][0];
      pr_ff[3] <= e_ff[0][0] * e_ff[1][2];
      pr_ff[4] <= e_ff[0][0] * e_ff[1][1];
      pr_ff[5] <= e_ff[0][1] * e_ff[1][0];
      cm_ff <= cm_in;
      cneg_ff[3] <= cneg_in;
      deg_ff[3] <= (cm_in[0] | cm_in[1] | cm_in[2]) == '0;
      for (int s = 4; s <= 7; s++) begin
         cneg_ff[s] <= cneg_ff[s-1];
         deg_ff[s]  <= deg_ff[s-1];
      end
      lead_ff <= lead_in;
      cm4_ff  <= cm_ff;
      nm_ff[5] <= nm_in;
      nm_ff[6] <= nm_ff[5];
      nm_ff[7] <= nm_ff[6];
      for (int j = 0; j < 3; j++) begin
         sq_ff[j] <= nm_ff[5][j] * nm_ff[5][j];
      end
      sum_ff <= SUM_BITS'(sq_ff[0]) + SUM_BITS'(sq_ff[1]) + SUM_BITS'(sq_ff[2]);
   end

   // Square-root cell row
   logic                     sq_v [NSQ+1];
   sqrt_type                 sq_d [NSQ+1];
   logic [SQ_SIDE_W-1:0]     sq_s [NSQ+1];

   assign sq_v[0] = v7_ff;
   assign sq_d[0] = '{radicand: sum_ff, rem: '0, root: '0};
   assign sq_s[0] = {deg_ff[7], cneg_ff[7], nm_ff[7][0], nm_ff[7][1], nm_ff[7][2], p_ff[7]};

   for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
      pfp_sqrt_cell #(.SIDE_W(SQ_SIDE_W)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (sq_v[g]),
         .in_data   (sq_d[g]),
         .in_side   (sq_s[g]),
         .out_valid (sq_v[g+1]),
         .out_data  (sq_d[g+1]),
         .out_side  (sq_s[g+1])
      );
   end

   // Divider setup
   logic                      ds_v_ff;
   logic [RB-1:0]             ds_r_ff;
   logic [2:0][RB+QB-1:0]     ds_w_ff;
   logic [2:0][RB+QB-1:0]     ds_w_in;
   logic [DIV_SIDE_W-1:0]     ds_s_ff;
   logic [NORM_BITS-1:0]      snm [3];
   logic [F+NORM_BITS:0]      num;
   logic [RB-1:0]             root;

   always_comb begin
      root = sq_d[NSQ].root;
      {snm[0], snm[1], snm[2]} = sq_s[NSQ][3*CB +: 3*NORM_BITS];
      for (int j = 0; j < 3; j++) begin
         num = {1'b0, snm[j], {F{1'b0}}} + (F+NORM_BITS+1)'(root >> 1);
         ds_w_in[j] = {RB'(num[F+NORM_BITS:QB]), num[QB-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ds_v_ff <= 1'b0;
      end else begin
         ds_v_ff <= sq_v[NSQ];
      end
      ds_r_ff <= root;
      ds_w_ff <= ds_w_in;
      ds_s_ff <= {sq_s[NSQ][SQ_SIDE_W-1 -: 4], sq_s[NSQ][3*CB-1:0]};
   end

   // Divider cell row
   logic                      dv_v [QB+1];
   logic [RB-1:0]             dv_r [QB+1];
   logic [2:0][RB+QB-1:0]     dv_w [QB+1];
   logic [DIV_SIDE_W-1:0]     dv_s [QB+1];

   assign dv_v[0] = ds_v_ff;
   assign dv_r[0] = ds_r_ff;
   assign dv_w[0] = ds_w_ff;
   assign dv_s[0] = ds_s_ff;

   for (genvar g = 0; g < QB; g++) begin : g_div
      pfp_div_cell #(.QB(QB), .SIDE_W(DIV_SIDE_W)) u_cell (
         .clock       (clock),
         .reset       (reset),
         .in_valid    (dv_v[g]),
         .in_divisor  (dv_r[g]),
         .in_work     (dv_w[g]),
         .in_side     (dv_s[g]),
         .out_valid   (dv_v[g+1]),
         .out_divisor (dv_r[g+1]),
         .out_work    (dv_w[g+1]),
         .out_side    (dv_s[g+1])
      );
   end

   // Back end: normal, projection, offset
   logic                      b1_v_ff, b2_v_ff, o_v_ff;
   logic signed [NW-1:0]      n_ff [3];
   logic signed [NW-1:0]      n_in [3];
   logic signed [PW-1:0]      dp_ff [3];
   proj_type                  pj_ff, pj2_ff, pj_in;
   logic                      dg_ff, dg2_ff;
   logic signed [NW-1:0]      n2_ff [3];
   logic [QB-1:0]             qa [3];
   logic [2:0]                bneg;
   logic                      bdeg;
   logic signed [CB-1:0]      bp [3];
   logic signed [DW-1:0]      dot;
   logic                      dneg_ff;
   logic [DW-1:0]             dmag_ff;

   always_comb begin
      {bdeg, bneg, bp[0], bp[1], bp[2]} = dv_s[QB];
      for (int j = 0; j < 3; j++) begin
         qa[j] = dv_w[QB][j][QB-1:0];
         if (qa[j] > (QB'(1) << F)) begin
            qa[j] = QB'(1) << F;
         end
         n_in[j] = bneg[j] ? -$signed({1'b0, qa[j]}) : $signed({1'b0, qa[j]});
      end
      if (qa[1] > qa[0] && qa[1] > qa[2]) begin
         pj_in = PROJ_XZ;
      end else if (qa[2] > qa[0] && qa[2] > qa[1]) begin
         pj_in = PROJ_XY;
      end else begin
         pj_in = PROJ_YZ;
      end
      dot = DW'(dp_ff[0]) + DW'(dp_ff[1]) + DW'(dp_ff[2]);
   end

   logic [RW-1:0]             rm;
   logic [RW-1:0]             rs;
   logic signed [OFFSET_BITS-1:0] off_in;

   localparam int SH_R = (OFFSET_FRAC_BITS <= F) ? F - OFFSET_FRAC_BITS : 0;
   localparam int SH_L = (OFFSET_FRAC_BITS > F) ? OFFSET_FRAC_BITS - F : 0;
   localparam logic [RW-1:0] MAX_MAG = RW'(1) << (OFFSET_BITS - 1);

   always_comb begin
      rm = RW'(dmag_ff);
      if (SH_L > 0) begin
         if ((rm >> 40) != '0) begin
            rm = RW'(1) << 40;
         end
         rs = rm << SH_L;
      end else if (SH_R > 0) begin
         rs = (rm + (RW'(1) << (SH_R - 1))) >> SH_R;
      end else begin
         rs = rm;
      end
      if (dneg_ff) begin
         if (rs > MAX_MAG) begin
            rs = MAX_MAG;
         end
         off_in = OFFSET_BITS'(-rs);
      end else begin
         if (rs > MAX_MAG - 1'b1) begin
            rs = MAX_MAG - 1'b1;
         end
         off_in = OFFSET_BITS'(rs);
      end
   end

   logic signed [NORMAL_BITS-1:0]  nx_ff, ny_ff, nz_ff;
   logic signed [OFFSET_BITS-1:0]  off_ff;
   proj_type                       pjo_ff;
   logic                           dgo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_v_ff <= 1'b0;
         b2_v_ff <= 1'b0;
         o_v_ff  <= 1'b0;
      end else begin
         b1_v_ff <= dv_v[QB];
         b2_v_ff <= b1_v_ff;
         o_v_ff  <= b2_v_ff;
      end
      n_ff  <= n_in;
      pj_ff <= pj_in;
      dg_ff <= bdeg;
      for (int j = 0; j < 3; j++) begin
         dp_ff[j] <= n_in[j] * bp[j];
      end
      n2_ff   <= n_ff;
      pj2_ff  <= pj_ff;
      dg2_ff  <= dg_ff;
      dneg_ff <= dot > 0;
      dmag_ff <= dot[DW-1] ? DW'(-dot) : DW'(dot);
      if (dg2_ff) begin
         nx_ff  <= '0;
         ny_ff  <= '0;
         nz_ff  <= '0;
         off_ff <= '0;
         pjo_ff <= PROJ_YZ;
      end else begin
         nx_ff  <= NORMAL_BITS'(n2_ff[0]);
         ny_ff  <= NORMAL_BITS'(n2_ff[1]);
         nz_ff  <= NORMAL_BITS'(n2_ff[2]);
         off_ff <= off_in;
         pjo_ff <= pj2_ff;
      end
      dgo_ff <= dg2_ff;
   end

   assign busy                 = 1'b0;
   assign rsp_valid            = o_v_ff;
   assign rsp_normal_x         = nx_ff;
   assign rsp_normal_y         = ny_ff;
   assign rsp_normal_z         = nz_ff;
   assign rsp_plane_offset     = off_ff;
   assign rsp_projection_plane = pjo_ff;
   assign rsp_degenerate       = dgo_ff;

endmodule

>>> rtl/core/pfp_checker.sv
// ----------------------------------------------------------------------------
// pfp_checker: port-level checks of the plane-from-three-points unit
// Watches the command and result ports for busy, latency, bounds and the
// degenerate result.
// ----------------------------------------------------------------------------
module pfp_checker #(
   parameter int NORMAL_FRAC_BITS = 30
) (
   input logic                                     clock,
   input logic                                     reset,
   input logic                                     start,
   input logic                                     busy,
   input logic                                     rsp_valid,
   input logic signed [pfp_pkg::NORMAL_BITS-1:0]   rsp_normal_x,
   input logic signed [pfp_pkg::NORMAL_BITS-1:0]   rsp_normal_y,
   input logic signed [pfp_pkg::NORMAL_BITS-1:0]   rsp_normal_z,
   input logic signed [pfp_pkg::OFFSET_BITS-1:0]   rsp_plane_offset,
   input logic [1:0]                               rsp_projection_plane,
   input logic                                     rsp_degenerate
);
   import pfp_pkg::*;

   localparam int LATENCY = NORMAL_FRAC_BITS + 44;
   localparam logic signed [NORMAL_BITS-1:0] ONE = NORMAL_BITS'(1) << NORMAL_FRAC_BITS;

   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LATENCY))
      else $error("result without a transaction at the pipeline latency");

   a_degenerate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_normal_x == 0 && rsp_normal_y == 0 &&
         rsp_normal_z == 0 && rsp_plane_offset == 0 &&
         rsp_projection_plane == PROJ_YZ)
      else $error("degenerate result not cleared");

   a_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_normal_x <= ONE && rsp_normal_x >= -ONE &&
         rsp_normal_y <= ONE && rsp_normal_y >= -ONE &&
         rsp_normal_z <= ONE && rsp_normal_z >= -ONE)
      else $error("normal component beyond unit magnitude");

endmodule

bind plane_from_three_points_unit pfp_checker #(
   .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
) u_pfp_checker (.*);
